>>> design/tid_pkg.sv
// Shared types and constants for the Tomasulo issue/dispatch/write-back core.
// No dependencies.
package tid_pkg;

  localparam int unsigned ADD_STATIONS = 3;
  localparam int unsigned MUL_STATIONS = 2;
  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned DATA_WIDTH   = 32;
  localparam int unsigned NUM_CFG      = 8;
  localparam int unsigned LAT_W        = 8;
  localparam int unsigned SEQ_W        = 16;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_ADDI = 3'd2,
    OP_SUBI = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_MULI = 3'd6,
    OP_DIVI = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_SEL,
    ST_CALC,
    ST_BCAST,
    ST_DEC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               operation;
    logic               issue_valid;
    logic [2:0]         opcode;
    logic [2:0]         dest_reg;
    logic [2:0]         src1_reg;
    logic [15:0]        src2_or_imm;
    logic signed [31:0] preload_value;
  } in_item_t;

  typedef struct packed {
    logic               issue_accepted;
    logic [15:0]        issued_seq;
    logic               add_dispatch_valid;
    logic [15:0]        add_dispatch_seq;
    logic               mul_dispatch_valid;
    logic [15:0]        mul_dispatch_seq;
    logic               wb_valid;
    logic [15:0]        wb_seq;
    logic [2:0]         wb_dest;
    logic signed [31:0] wb_value;
    logic               div_by_zero;
    logic               all_idle;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic dz;
  } alu_rsp_t;

endpackage

>>> design/tomasulo_issue_dispatch_writeback_core.sv
// Top level: Tomasulo scheduler tick sequencer, stations, alias table, register file.
// Depends on tid_pkg and tid_alu.
//
// Usage: one input item is one scheduler tick (or a register preload). An item is
// taken when in_valid_i is high and in_stall_o low; in_stall_o stays high until the
// result item of that tick has been taken on the output channel.
// Steps: a tick passes through accept, dispatch, select, calculate (a multiply or
// divide write-back only, in the shared multiply/divide unit), broadcast (write-back
// only), decrement and output; a preload goes from accept straight to output. No new
// item is taken before the result item of the last one has been taken.
// The result is held in registers while out_stall_i is high; nothing else moves but cfg_we_i writes.
// Reset clears stations, alias table, register file, units, the sequence counter and
// sets every latency register to its smallest non-zero value. cfg_we_i writes a latency register by index.
module tomasulo_issue_dispatch_writeback_core import tid_pkg::*; #(
  parameter int unsigned AddStations = ADD_STATIONS,
  parameter int unsigned MulStations = MUL_STATIONS,
  parameter int unsigned NumRegs     = NUM_REGS,
  parameter int unsigned DataWidth   = DATA_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [LAT_W-1:0] cfg_data_i
);

  localparam int unsigned Nst = AddStations + MulStations;
  localparam int unsigned Sw  = $clog2(Nst);
  localparam int unsigned Rw  = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam int unsigned Dw  = DataWidth;

  state_e state_q, state_d;

  logic [LAT_W-1:0] lat_q [NUM_CFG];

  logic             st_busy_q  [Nst];
  logic [2:0]       st_op_q    [Nst];
  logic [SEQ_W-1:0] st_seq_q   [Nst];
  logic [Rw-1:0]    st_dest_q  [Nst];
  logic [Dw-1:0]    st_va_q    [Nst];
  logic [Dw-1:0]    st_vb_q    [Nst];
  logic             st_ra_q    [Nst];
  logic             st_rb_q    [Nst];
  logic [Sw-1:0]    st_ta_q    [Nst];
  logic [Sw-1:0]    st_tb_q    [Nst];

  logic             al_wait_q [NumRegs];
  logic [Sw-1:0]    al_tag_q  [NumRegs];
  logic [Dw-1:0]    rf_q      [NumRegs];

  logic             u_busy_q [2];
  logic [Sw-1:0]    u_st_q   [2];
  logic [LAT_W-1:0] u_cd_q   [2];

  logic [SEQ_W-1:0] seq_cnt_q;
  logic             issued_q;
  logic [SEQ_W-1:0] iseq_q;
  logic             wb_u_q;
  logic [Sw-1:0]    wb_st_q;
  logic [Dw-1:0]    res_q;
  logic             dz_q;
  out_item_t        out_q;

  logic             idle_w;
  logic             accept_w;
  logic [Rw-1:0]    dest_w, src1_w, src2_w;
  logic             free_found;
  logic [Sw-1:0]    free_s;
  logic             imm_w;
  logic signed [63:0] pl_ext;
  logic [63:0]      imm_ext;
  logic             pick_ok [2];
  logic [Sw-1:0]    pick_s  [2];
  logic             wb_hit;
  logic             wb_u;
  logic [Sw-1:0]    wb_st;
  logic [Dw-1:0]    addsub_w;
  logic [Rw-1:0]    wb_d;
  logic signed [63:0] res_ext;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [Dw-1:0]    alu_res;

  function automatic logic [LAT_W-1:0] lat_of(input logic [LAT_W-1:0] v);
    lat_of = (v == '0) ? LAT_W'(1) : v;
  endfunction

  function automatic logic older(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    older = d[SEQ_W-1];
  endfunction

  assign accept_w = in_valid_i && !in_stall_o;
  assign dest_w   = Rw'(32'(in_i.dest_reg) % NumRegs);
  assign src1_w   = Rw'(32'(in_i.src1_reg) % NumRegs);
  assign src2_w   = Rw'(32'(in_i.src2_or_imm) % NumRegs);
  assign imm_w    = in_i.opcode inside {OP_ADDI, OP_SUBI, OP_MULI, OP_DIVI};
  assign pl_ext   = 64'(in_i.preload_value);
  assign imm_ext  = 64'(in_i.src2_or_imm);

  always_comb begin
    idle_w = !u_busy_q[0] && !u_busy_q[1];
    for (int s = 0; s < Nst; s++) begin
      if (st_busy_q[s]) idle_w = 1'b0;
    end
  end

  always_comb begin
    int lo, hi;
    lo = (in_i.opcode[2]) ? AddStations : 0;
    hi = (in_i.opcode[2]) ? Nst : AddStations;
    free_found = 1'b0;
    free_s     = '0;
    for (int s = 0; s < Nst; s++) begin
      if (s >= lo && s < hi && !st_busy_q[s] && !free_found) begin
        free_found = 1'b1;
        free_s     = Sw'(s);
      end
    end
  end

  always_comb begin
    for (int u = 0; u < 2; u++) begin
      pick_ok[u] = 1'b0;
      pick_s[u]  = '0;
      for (int s = 0; s < Nst; s++) begin
        if (((u == 0) ? (s < AddStations) : (s >= AddStations)) && st_busy_q[s] &&
            st_ra_q[s] && st_rb_q[s] && !(issued_q && st_seq_q[s] == iseq_q) &&
            (!pick_ok[u] || older(st_seq_q[s], st_seq_q[pick_s[u]]))) begin
          pick_ok[u] = 1'b1;
          pick_s[u]  = Sw'(s);
        end
      end
    end
  end

  always_comb begin
    wb_hit = 1'b0;
    wb_u   = 1'b0;
    if (u_busy_q[0] && u_cd_q[0] == '0) begin
      wb_hit = 1'b1;
    end else if (u_busy_q[1] && u_cd_q[1] == '0) begin
      wb_hit = 1'b1;
      wb_u   = 1'b1;
    end
    wb_st    = u_st_q[wb_u];
    addsub_w = st_op_q[wb_st][0] ? (st_va_q[wb_st] - st_vb_q[wb_st])
                                 : (st_va_q[wb_st] + st_vb_q[wb_st]);
    wb_d     = st_dest_q[wb_st_q];
    res_ext  = 64'($signed(res_q));
  end

  tid_alu #(.DataWidth(DataWidth)) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (st_va_q[wb_st]),
    .b_i   (st_vb_q[wb_st]),
    .rsp_o (alu_rsp),
    .res_o (alu_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept_w) state_d = in_i.operation ? ST_OUT : ST_DISP;
      ST_DISP:  state_d = ST_SEL;
      ST_SEL: begin
        if (!wb_hit)                 state_d = ST_DEC;
        else if (st_op_q[wb_st][2])  state_d = ST_CALC;
        else                         state_d = ST_BCAST;
      end
      ST_CALC:  if (alu_rsp.done) state_d = ST_BCAST;
      ST_BCAST: state_d = ST_DEC;
      ST_DEC:   state_d = ST_OUT;
      ST_OUT:   if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = (state_q == ST_OUT);
    out_o         = out_q;
    alu_req.start = (state_q == ST_SEL) && wb_hit && st_op_q[wb_st][2];
    alu_req.div   = st_op_q[wb_st][0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) lat_q[i] <= LAT_W'(1);
      for (int s = 0; s < Nst; s++) st_busy_q[s] <= 1'b0;
      for (int r = 0; r < NumRegs; r++) begin
        al_wait_q[r] <= 1'b0;
        al_tag_q[r]  <= '0;
        rf_q[r]      <= '0;
      end
      for (int u = 0; u < 2; u++) begin
        u_busy_q[u] <= 1'b0;
        u_st_q[u]   <= '0;
        u_cd_q[u]   <= '0;
      end
      seq_cnt_q <= '0;
      issued_q  <= 1'b0;
      iseq_q    <= '0;
      wb_u_q    <= 1'b0;
      wb_st_q   <= '0;
      res_q     <= '0;
      dz_q      <= 1'b0;
      out_q     <= '0;
    end else begin
      if (cfg_we_i) lat_q[cfg_idx_i] <= cfg_data_i;
      case (state_q)
        ST_IDLE: begin
          if (accept_w) begin
            if (in_i.operation) begin
              if (idle_w) rf_q[dest_w] <= pl_ext[Dw-1:0];
              issued_q <= 1'b0;
              out_q    <= '{all_idle: idle_w, default: '0};
            end else if (in_i.issue_valid && free_found) begin
              st_busy_q[free_s] <= 1'b1;
              st_op_q[free_s]   <= in_i.opcode;
              st_seq_q[free_s]  <= seq_cnt_q;
              st_dest_q[free_s] <= dest_w;
              if (imm_w) begin
                st_vb_q[free_s] <= imm_ext[Dw-1:0];
                st_rb_q[free_s] <= 1'b1;
                st_tb_q[free_s] <= '0;
              end else begin
                st_vb_q[free_s] <= al_wait_q[src2_w] ? '0 : rf_q[src2_w];
                st_rb_q[free_s] <= !al_wait_q[src2_w];
                st_tb_q[free_s] <= al_wait_q[src2_w] ? al_tag_q[src2_w] : '0;
              end
              st_va_q[free_s] <= al_wait_q[src1_w] ? '0 : rf_q[src1_w];
              st_ra_q[free_s] <= !al_wait_q[src1_w];
              st_ta_q[free_s] <= al_wait_q[src1_w] ? al_tag_q[src1_w] : '0;
              al_wait_q[dest_w] <= 1'b1;
              al_tag_q[dest_w]  <= free_s;
              seq_cnt_q         <= seq_cnt_q + 1'b1;
              issued_q          <= 1'b1;
              iseq_q            <= seq_cnt_q;
              out_q <= '{issue_accepted: 1'b1, issued_seq: seq_cnt_q, default: '0};
            end else begin
              issued_q <= 1'b0;
              out_q    <= '0;
            end
          end
        end
        ST_DISP: begin
          for (int u = 0; u < 2; u++) begin
            if (!u_busy_q[u] && pick_ok[u]) begin
              u_busy_q[u] <= 1'b1;
              u_st_q[u]   <= pick_s[u];
              u_cd_q[u]   <= lat_of(lat_q[st_op_q[pick_s[u]]]) - 1'b1;
            end
          end
          if (!u_busy_q[0] && pick_ok[0]) begin
            out_q.add_dispatch_valid <= 1'b1;
            out_q.add_dispatch_seq   <= st_seq_q[pick_s[0]];
          end
          if (!u_busy_q[1] && pick_ok[1]) begin
            out_q.mul_dispatch_valid <= 1'b1;
            out_q.mul_dispatch_seq   <= st_seq_q[pick_s[1]];
          end
        end
        ST_SEL: begin
          wb_u_q  <= wb_u;
          wb_st_q <= wb_st;
          res_q   <= addsub_w;
          dz_q    <= 1'b0;
        end
        ST_CALC: begin
          if (alu_rsp.done) begin
            res_q <= alu_res;
            dz_q  <= alu_rsp.dz;
          end
        end
        ST_BCAST: begin
          if (al_wait_q[wb_d] && al_tag_q[wb_d] == wb_st_q) begin
            al_wait_q[wb_d] <= 1'b0;
            rf_q[wb_d]      <= res_q;
          end
          for (int s = 0; s < Nst; s++) begin
            if (st_busy_q[s] && !st_ra_q[s] && st_ta_q[s] == wb_st_q) begin
              st_ra_q[s] <= 1'b1;
              st_va_q[s] <= res_q;
            end
            if (st_busy_q[s] && !st_rb_q[s] && st_tb_q[s] == wb_st_q) begin
              st_rb_q[s] <= 1'b1;
              st_vb_q[s] <= res_q;
            end
          end
          st_busy_q[wb_st_q] <= 1'b0;
          u_busy_q[wb_u_q]   <= 1'b0;
          out_q.wb_valid    <= 1'b1;
          out_q.wb_seq      <= st_seq_q[wb_st_q];
          out_q.wb_dest     <= 3'(wb_d);
          out_q.wb_value    <= res_ext[31:0];
          out_q.div_by_zero <= dz_q;
        end
        ST_DEC: begin
          for (int u = 0; u < 2; u++) begin
            if (u_busy_q[u] && u_cd_q[u] != '0) u_cd_q[u] <= u_cd_q[u] - 1'b1;
          end
          out_q.all_idle <= idle_w;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/tid_alu.sv
// Shared iterative multiply / signed divide unit, one bit per cycle.
// Depends on tid_pkg.
module tid_alu import tid_pkg::*; #(
  parameter int unsigned DataWidth = DATA_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alu_req_t             req_i,
  input  logic [DataWidth-1:0] a_i,
  input  logic [DataWidth-1:0] b_i,
  output alu_rsp_t             rsp_o,
  output logic [DataWidth-1:0] res_o
);

  localparam int unsigned CntW = $clog2(DataWidth + 1);

  logic                 busy_q, div_q, neg_q, dz_q;
  logic [CntW-1:0]      cnt_q;
  logic [DataWidth:0]   acc_q;
  logic [DataWidth-1:0] x_q, y_q;
  logic [DataWidth:0]   rem_w;
  logic                 ge_w;
  logic [DataWidth-1:0] mag_a, mag_b;

  assign mag_a = a_i[DataWidth-1] ? (DataWidth'(0) - a_i) : a_i;
  assign mag_b = b_i[DataWidth-1] ? (DataWidth'(0) - b_i) : b_i;
  assign rem_w = {acc_q[DataWidth-1:0], y_q[DataWidth-1]};
  assign ge_w  = rem_w >= {1'b0, x_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      neg_q  <= 1'b0;
      dz_q   <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      div_q  <= req_i.div;
      acc_q  <= '0;
      if (req_i.div) begin
        dz_q  <= (b_i == '0);
        neg_q <= a_i[DataWidth-1] ^ b_i[DataWidth-1];
        x_q   <= mag_b;
        y_q   <= mag_a;
        cnt_q <= (b_i == '0) ? '0 : CntW'(DataWidth);
      end else begin
        dz_q  <= 1'b0;
        neg_q <= 1'b0;
        x_q   <= a_i;
        y_q   <= b_i;
        cnt_q <= CntW'(DataWidth);
      end
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
        if (div_q) begin
          acc_q <= ge_w ? (rem_w - {1'b0, x_q}) : rem_w;
          y_q   <= {y_q[DataWidth-2:0], ge_w};
        end else begin
          if (y_q[0]) acc_q <= {1'b0, acc_q[DataWidth-1:0] + x_q};
          x_q <= {x_q[DataWidth-2:0], 1'b0};
          y_q <= {1'b0, y_q[DataWidth-1:1]};
        end
      end
    end
  end

  always_comb begin
    rsp_o.done = busy_q && (cnt_q == '0);
    rsp_o.dz   = dz_q;
    if (!div_q)     res_o = acc_q[DataWidth-1:0];
    else if (dz_q)  res_o = '0;
    else if (neg_q) res_o = DataWidth'(0) - y_q;
    else            res_o = y_q;
  end

endmodule
